// File: rtl/polynomial_back_bounce_easing_top_assert.svh
// Assertion macros for the easing pipeline
`ifndef POLYNOMIAL_BACK_BOUNCE_EASING_TOP_ASSERT_SVH
`define POLYNOMIAL_BACK_BOUNCE_EASING_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define PBBE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define PBBE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/pbbe_pkg.sv
// Shared types, widths and curve codes of the easing block
`timescale 1ns / 1ps
`default_nettype none

package pbbe_pkg;

    localparam int FUNC_W = 5;
    localparam int PROG_W = 18;
    localparam int VAL_W  = 32;
    localparam int OVS_W  = 15;

    // curve codes
    localparam logic [FUNC_W-1:0] FN_QUAD_IN     = 5'd0;
    localparam logic [FUNC_W-1:0] FN_QUAD_OUT    = 5'd1;
    localparam logic [FUNC_W-1:0] FN_QUAD_INOUT  = 5'd2;
    localparam logic [FUNC_W-1:0] FN_CUBIC_IN    = 5'd3;
    localparam logic [FUNC_W-1:0] FN_CUBIC_OUT   = 5'd4;
    localparam logic [FUNC_W-1:0] FN_CUBIC_INOUT = 5'd5;
    localparam logic [FUNC_W-1:0] FN_QUART_IN    = 5'd6;
    localparam logic [FUNC_W-1:0] FN_QUART_OUT   = 5'd7;
    localparam logic [FUNC_W-1:0] FN_QUART_INOUT = 5'd8;
    localparam logic [FUNC_W-1:0] FN_QUINT_IN    = 5'd9;
    localparam logic [FUNC_W-1:0] FN_QUINT_OUT   = 5'd10;
    localparam logic [FUNC_W-1:0] FN_QUINT_INOUT = 5'd11;
    localparam logic [FUNC_W-1:0] FN_BACK_IN     = 5'd12;
    localparam logic [FUNC_W-1:0] FN_BACK_OUT    = 5'd13;
    localparam logic [FUNC_W-1:0] FN_BACK_INOUT  = 5'd14;
    localparam logic [FUNC_W-1:0] FN_BNC_IN      = 5'd15;
    localparam logic [FUNC_W-1:0] FN_BNC_OUT     = 5'd16;
    localparam logic [FUNC_W-1:0] FN_BNC_INOUT   = 5'd17;

    typedef enum logic [1:0] {
        K_NONE   = 2'd0,
        K_POLY   = 2'd1,
        K_BACK   = 2'd2,
        K_BOUNCE = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        D_IN    = 2'd0,
        D_OUT   = 2'd1,
        D_INOUT = 2'd2
    } dir_t;

    // pw: power minus two for the polynomial curves
    typedef struct packed {
        kind_t      kind;
        dir_t       dir;
        logic [1:0] pw;
    } mode_t;

    function automatic mode_t pbbe_decode(input logic [FUNC_W-1:0] fn);
        mode_t m;
        m = '{kind: K_NONE, dir: D_IN, pw: 2'd0};
        unique case (fn)
            FN_QUAD_IN:     m = '{kind: K_POLY, dir: D_IN,    pw: 2'd0};
            FN_QUAD_OUT:    m = '{kind: K_POLY, dir: D_OUT,   pw: 2'd0};
            FN_QUAD_INOUT:  m = '{kind: K_POLY, dir: D_INOUT, pw: 2'd0};
            FN_CUBIC_IN:    m = '{kind: K_POLY, dir: D_IN,    pw: 2'd1};
            FN_CUBIC_OUT:   m = '{kind: K_POLY, dir: D_OUT,   pw: 2'd1};
            FN_CUBIC_INOUT: m = '{kind: K_POLY, dir: D_INOUT, pw: 2'd1};
            FN_QUART_IN:    m = '{kind: K_POLY, dir: D_IN,    pw: 2'd2};
            FN_QUART_OUT:   m = '{kind: K_POLY, dir: D_OUT,   pw: 2'd2};
            FN_QUART_INOUT: m = '{kind: K_POLY, dir: D_INOUT, pw: 2'd2};
            FN_QUINT_IN:    m = '{kind: K_POLY, dir: D_IN,    pw: 2'd3};
            FN_QUINT_OUT:   m = '{kind: K_POLY, dir: D_OUT,   pw: 2'd3};
            FN_QUINT_INOUT: m = '{kind: K_POLY, dir: D_INOUT, pw: 2'd3};
            FN_BACK_IN:     m = '{kind: K_BACK, dir: D_IN,    pw: 2'd0};
            FN_BACK_OUT:    m = '{kind: K_BACK, dir: D_OUT,   pw: 2'd0};
            FN_BACK_INOUT:  m = '{kind: K_BACK, dir: D_INOUT, pw: 2'd0};
            FN_BNC_IN:      m = '{kind: K_BOUNCE, dir: D_IN,    pw: 2'd0};
            FN_BNC_OUT:     m = '{kind: K_BOUNCE, dir: D_OUT,   pw: 2'd0};
            FN_BNC_INOUT:   m = '{kind: K_BOUNCE, dir: D_INOUT, pw: 2'd0};
            default:        m = '{kind: K_NONE, dir: D_IN,    pw: 2'd0};
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

// File: rtl/pbbe_ifs.sv
// Handshake channels of the easing block: input words, result words, config
`timescale 1ns / 1ps
`default_nettype none

interface pbbe_item_if
    import pbbe_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic [FUNC_W-1:0]        func;
    logic signed [PROG_W-1:0] progress;
    logic signed [VAL_W-1:0]  start_value;
    logic signed [VAL_W-1:0]  end_value;

    modport source (output valid, func, progress, start_value, end_value, input ready);
    modport sink   (input valid, func, progress, start_value, end_value, output ready);
endinterface

interface pbbe_result_if
    import pbbe_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] eased_value;

    modport source (output valid, eased_value, input ready);
    modport sink   (input valid, eased_value, output ready);
endinterface

interface pbbe_cfg_if
    import pbbe_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [OVS_W-1:0] overshoot;

    modport source (output valid, overshoot, input ready);
    modport sink   (input valid, overshoot, output ready);
endinterface

`default_nettype wire

// File: rtl/polynomial_back_bounce_easing_top.sv
// An accepted input word passes through stage registers 1 to 5, the stage 6 and 7 registers and the output register.
// Throughput: one word per cycle; the whole pipe holds while the output word waits.
// Depth is set by the chain of up to four rounded multiplies of the quintic curves.
// Reset (rst_n low, asynchronous) empties the pipe and loads the default overshoot.
`timescale 1ns / 1ps
`default_nettype none
`include "polynomial_back_bounce_easing_top_assert.svh"

module polynomial_back_bounce_easing_top
    import pbbe_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  wire            clk,
    input  wire            rst_n,
    pbbe_item_if.sink      items,
    pbbe_result_if.source  results,
    pbbe_cfg_if.sink       cfg
);

    localparam int F  = FRAC_BITS;
    localparam int XW = F + 2;          // signed curve argument
    localparam int AW = F + 8;          // signed accumulator
    localparam int SW = F + 4;          // unsigned overshoot terms
    localparam int KW = F + 5;          // signed overshoot plus one
    localparam int YW = F + 4;          // signed bounce offset
    localparam int EW = F + 4;          // signed eased fraction
    localparam int PW = 33 + EW;        // final product

    localparam longint ONE_L  = longint'(1) << F;
    localparam longint HALF_L = ONE_L >> 1;
    localparam longint C_L    = (1525 * ONE_L + 500) / 1000;
    localparam longint S_RST  = (6970 * ONE_L + 2048) / 4096;
    localparam longint S2_RST = (S_RST * C_L + HALF_L) >> F;
    localparam logic [F:0] C_VEC = C_L[F:0];

    typedef struct packed {
        logic                   v;
        mode_t                  md;
        logic                   hi;
        logic signed [XW-1:0]   x;
        logic signed [31:0]     st;
        logic signed [32:0]     diff;
        logic signed [AW-1:0]   acc;
        logic signed [AW-1:0]   aux;
    } stage_t;

    // round to nearest, ties away from zero, after a right shift by n
    function automatic longint rnd_shr(input longint val, input int n);
        longint mag;
        longint r;
        mag = (val < 0) ? -val : val;
        r   = (mag + (longint'(1) << (n - 1))) >>> n;
        return (val < 0) ? -r : r;
    endfunction

    logic adv;

    // overshoot terms s and s2, formed when the register is written
    logic [SW-1:0]       ov_s_reg, ov_s2_reg;
    logic [SW-1:0]       ov_s_next, ov_s2_next;
    longint              cfg_s_full;
    logic [SW+F:0]       s2_prod;
    logic [SW+F:0]       s2_round;

    always_comb
    begin
        cfg_s_full = ((longint'(cfg.overshoot) << F) + 2048) >>> 12;
        ov_s_next  = cfg_s_full[SW-1:0];
        s2_prod    = ov_s_next * C_VEC;
        s2_round   = s2_prod + (SW+F+1)'(HALF_L);
        ov_s2_next = s2_round[SW+F-1:F];
    end

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_s_reg  <= S_RST[SW-1:0];
            ov_s2_reg <= S2_RST[SW-1:0];
        end
        else if (cfg.valid)
        begin
            ov_s_reg  <= ov_s_next;
            ov_s2_reg <= ov_s2_next;
        end
    end

    // pipe control: all stages move together unless the output word is held
    logic                  out_v_reg;
    logic signed [31:0]    out_d_reg;

    assign adv          = !out_v_reg || results.ready;
    assign items.ready  = adv;

    stage_t stg_reg  [1:5];
    stage_t stg_next [1:5];

    // stage 1: clamp t, pick the curve argument, form end minus start
    always_comb
    begin
        longint tl;
        longint xl;
        mode_t  md;
        logic   hi;
        tl = longint'(items.progress);
        if (tl < 0)
        begin
            tl = 0;
        end
        else if (tl > ONE_L)
        begin
            tl = ONE_L;
        end
        hi = (tl >= HALF_L);
        md = pbbe_decode(items.func);
        xl = 0;
        unique case (md.kind)
            K_POLY:
            begin
                unique case (md.dir)
                    D_IN:    xl = tl;
                    D_OUT:   xl = ONE_L - tl;
                    default: xl = hi ? 2 * (ONE_L - tl) : 2 * tl;
                endcase
            end
            K_BACK:
            begin
                unique case (md.dir)
                    D_IN:    xl = tl;
                    D_OUT:   xl = tl - ONE_L;
                    default: xl = hi ? 2 * tl - 2 * ONE_L : 2 * tl;
                endcase
            end
            K_BOUNCE:
            begin
                unique case (md.dir)
                    D_IN:    xl = ONE_L - tl;
                    D_OUT:   xl = tl;
                    default: xl = hi ? 2 * tl - ONE_L : ONE_L - 2 * tl;
                endcase
            end
            default: xl = 0;
        endcase
        stg_next[1].v    = items.valid;
        stg_next[1].md   = md;
        stg_next[1].hi   = hi;
        stg_next[1].x    = xl[XW-1:0];
        stg_next[1].st   = items.start_value;
        stg_next[1].diff = {items.end_value[31], items.end_value}
                         - {items.start_value[31], items.start_value};
        stg_next[1].acc  = '0;
        stg_next[1].aux  = '0;
    end

    // stage 2: square for polynomial, back terms, whole bounce curve
    always_comb
    begin
        stage_t                 p;
        logic signed [2*XW-1:0] sq;
        logic [SW-1:0]          k;
        logic signed [KW-1:0]   kp;
        logic signed [KW+XW-1:0] mp;
        longint                 m;
        longint                 bl;
        longint                 x11;
        longint                 yl;
        longint                 off;
        logic                   wide;
        logic signed [YW-1:0]   y;
        logic signed [2*YW-1:0] ysq;
        p    = stg_reg[1];
        sq   = p.x * p.x;
        k    = (p.md.dir == D_INOUT) ? ov_s2_reg : ov_s_reg;
        kp   = $signed({1'b0, k}) + KW'(ONE_L);
        mp   = kp * p.x;
        m    = rnd_shr(longint'(mp), F);
        if (p.md.dir == D_OUT || (p.md.dir == D_INOUT && p.hi))
        begin
            bl = m + longint'(k);
        end
        else
        begin
            bl = m - longint'(k);
        end

        // bounce segments
        x11  = 11 * longint'(p.x);
        wide = 1'b0;
        if (x11 < 4 * ONE_L)
        begin
            yl  = x11;
            off = 0;
        end
        else if (x11 < 8 * ONE_L)
        begin
            yl  = x11 - 6 * ONE_L;
            off = (ONE_L * 48) >>> 6;
        end
        else if (x11 < 10 * ONE_L)
        begin
            yl  = x11 - 9 * ONE_L;
            off = (ONE_L * 60) >>> 6;
        end
        else
        begin
            yl   = 22 * longint'(p.x) - 21 * ONE_L;
            off  = (ONE_L * 63) >>> 6;
            wide = 1'b1;
        end
        y   = yl[YW-1:0];
        ysq = y * y;

        stg_next[2]     = p;
        stg_next[2].aux = '0;
        unique case (p.md.kind)
            K_POLY:
            begin
                stg_next[2].acc = AW'(rnd_shr(longint'(sq), F));
            end
            K_BACK:
            begin
                stg_next[2].acc = AW'(rnd_shr(longint'(sq), F));
                stg_next[2].aux = AW'(bl);
            end
            K_BOUNCE:
            begin
                stg_next[2].acc = wide ? AW'(rnd_shr(longint'(ysq), F + 6) + off)
                                       : AW'(rnd_shr(longint'(ysq), F + 4) + off);
            end
            default: stg_next[2].acc = '0;
        endcase
    end

    // stages 3 to 5: further powers; the back product in stage 3
    for (genvar j = 3; j <= 5; j++)
    begin : g_pow
        always_comb
        begin
            stage_t                    p;
            logic signed [2*XW-1:0]    pp;
            logic signed [XW+AW-1:0]   bp;
            p  = stg_reg[j-1];
            pp = $signed(p.acc[XW-1:0]) * p.x;
            bp = $signed(p.acc[XW-1:0]) * p.aux;
            stg_next[j] = p;
            if (p.md.kind == K_POLY && int'(p.md.pw) >= j - 2)
            begin
                stg_next[j].acc = AW'(rnd_shr(longint'(pp), F));
            end
            else if (p.md.kind == K_BACK && j == 3)
            begin
                stg_next[j].acc = AW'(rnd_shr(longint'(bp), F));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 1; j <= 5; j++)
            begin
                stg_reg[j] <= '0;
            end
        end
        else if (adv)
        begin
            stg_reg <= stg_next;
        end
    end

    // stage 6: fold the curve into the eased fraction
    logic                  v6_reg;
    logic signed [31:0]    st6_reg;
    logic signed [32:0]    diff6_reg;
    logic signed [EW-1:0]  e6_reg;
    logic signed [EW-1:0]  e6_next;

    always_comb
    begin
        stage_t p;
        longint a;
        longint el;
        p  = stg_reg[5];
        a  = longint'(p.acc);
        el = 0;
        unique case (p.md.kind)
            K_POLY:
            begin
                unique case (p.md.dir)
                    D_IN:    el = a;
                    D_OUT:   el = ONE_L - a;
                    default: el = p.hi ? ONE_L - rnd_shr(a, 1) : rnd_shr(a, 1);
                endcase
            end
            K_BACK:
            begin
                unique case (p.md.dir)
                    D_IN:    el = a;
                    D_OUT:   el = a + ONE_L;
                    default: el = p.hi ? rnd_shr(a + 2 * ONE_L, 1) : rnd_shr(a, 1);
                endcase
            end
            K_BOUNCE:
            begin
                unique case (p.md.dir)
                    D_IN:    el = ONE_L - a;
                    D_OUT:   el = a;
                    default: el = p.hi ? rnd_shr(ONE_L + a, 1) : rnd_shr(ONE_L - a, 1);
                endcase
            end
            default: el = 0;
        endcase
        e6_next = el[EW-1:0];
    end

    // stage 7: scale the span by the eased fraction
    logic                  v7_reg;
    logic signed [31:0]    st7_reg;
    logic signed [PW-1:0]  prod7_reg;
    logic signed [PW-1:0]  prod7_next;

    assign prod7_next = diff6_reg * e6_reg;

    // stage 8: add start and saturate
    logic signed [31:0]    out_d_next;

    always_comb
    begin
        longint rl;
        rl = longint'(st7_reg) + rnd_shr(longint'(prod7_reg), F);
        if (rl > 64'sh0000_0000_7FFF_FFFF)
        begin
            out_d_next = 32'sh7FFF_FFFF;
        end
        else if (rl < -64'sh0000_0000_8000_0000)
        begin
            out_d_next = 32'sh8000_0000;
        end
        else
        begin
            out_d_next = rl[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v6_reg    <= 1'b0;
            v7_reg    <= 1'b0;
            out_v_reg <= 1'b0;
            st6_reg   <= '0;
            diff6_reg <= '0;
            e6_reg    <= '0;
            st7_reg   <= '0;
            prod7_reg <= '0;
            out_d_reg <= '0;
        end
        else if (adv)
        begin
            v6_reg    <= stg_reg[5].v;
            st6_reg   <= stg_reg[5].st;
            diff6_reg <= stg_reg[5].diff;
            e6_reg    <= e6_next;
            v7_reg    <= v6_reg;
            st7_reg   <= st6_reg;
            prod7_reg <= prod7_next;
            out_v_reg <= v7_reg;
            out_d_reg <= out_d_next;
        end
    end

    assign results.valid       = out_v_reg;
    assign results.eased_value = out_d_reg;

    // checks
    `PBBE_ASSERT_NEXT(a_accept_enters, items.valid && items.ready, stg_reg[1].v,
        "accepted word did not enter stage 1")
    `PBBE_ASSERT_NEXT(a_undef_zero, adv && stg_reg[5].v && stg_reg[5].md.kind == K_NONE,
        e6_reg == '0, "undefined curve code gave a nonzero fraction")
    `PBBE_ASSERT_NOW(a_poly_range, stg_reg[5].v && stg_reg[5].md.kind == K_POLY,
        stg_reg[5].acc >= 0 && longint'(stg_reg[5].acc) <= ONE_L,
        "polynomial power left the unit range")
    `PBBE_ASSERT_NOW(a_s2_ge_s, 1'b1, ov_s2_reg >= ov_s_reg,
        "in-out overshoot below plain overshoot")
    `PBBE_ASSERT_NEXT(a_stall_holds, !adv, $stable(e6_reg) && $stable(prod7_reg),
        "pipe moved during a stall")

endmodule

`default_nettype wire

// File: verif/polynomial_back_bounce_easing_top_test.sv
// Self-checking bench for the easing block: Q16.16 curve prediction, result checks
`timescale 1ns / 1ps
`default_nettype none

module polynomial_back_bounce_easing_top_test;
    import pbbe_pkg::*;

    localparam int FB = 16;
    localparam longint ONE = 64'sd1 << FB;
    localparam longint HALF = ONE >>> 1;
    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 20;

    logic clk;
    logic rst_n;

    pbbe_item_if   item_ch ();
    pbbe_result_if res_ch ();
    pbbe_cfg_if    cfg_ch ();

    polynomial_back_bounce_easing_top #(.FRAC_BITS(FB)) u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (item_ch.sink),
        .results (res_ch.source),
        .cfg     (cfg_ch.sink)
    );

    // expected eased values, oldest first
    logic signed [VAL_W-1:0] eased_q[$];
    logic [OVS_W-1:0] overshoot_reg;
    int  send_idle_pct;
    int  recv_stall_pct;
    bit  hold_off;
    bit  failed;
    longint cycle_cnt;

    // clock
    initial clk = 1'b0;
    always #4 clk = ~clk;

    // rounded right shift, ties away from zero
    function automatic longint round_shift(input longint x, input int n);
        longint mag;
        mag = (x < 0) ? -x : x;
        mag = (mag + (64'sd1 <<< (n - 1))) >>> n;
        return (x < 0) ? -mag : mag;
    endfunction

    function automatic longint fx_mul(input longint a, input longint b);
        return round_shift(a * b, FB);
    endfunction

    function automatic longint fx_pow(input longint x, input int p);
        longint r;
        r = x;
        for (int i = 1; i < p; i++) r = fx_mul(r, x);
        return r;
    endfunction

    function automatic longint bounce_frac(input longint x);
        longint y;
        if (x * 11 < 4 * ONE) begin
            y = 11 * x;
            return round_shift(y * y, FB + 4);
        end
        if (x * 11 < 8 * ONE) begin
            y = 11 * x - 6 * ONE;
            return round_shift(y * y, FB + 4) + ((ONE * 48) >>> 6);
        end
        if (x * 11 < 10 * ONE) begin
            y = 11 * x - 9 * ONE;
            return round_shift(y * y, FB + 4) + ((ONE * 60) >>> 6);
        end
        y = 22 * x - 21 * ONE;
        return round_shift(y * y, FB + 6) + ((ONE * 63) >>> 6);
    endfunction

    // eased fraction for one curve code
    function automatic longint ease_frac(input logic [FUNC_W-1:0] fn, input longint t);
        longint s, s2, v, w;
        int p;
        s = (longint'(overshoot_reg) * ONE + 2048) / 4096;
        if (fn <= FN_QUINT_INOUT) begin
            p = fn / 3 + 2;
            case (fn % 3)
                0: return fx_pow(t, p);
                1: return ONE - fx_pow(ONE - t, p);
                default:
                begin
                    if (t < HALF) return round_shift(fx_pow(2 * t, p), 1);
                    return ONE - round_shift(fx_pow(2 * (ONE - t), p), 1);
                end
            endcase
        end
        case (fn)
            FN_BACK_IN: return fx_mul(fx_mul(t, t), fx_mul(s + ONE, t) - s);
            FN_BACK_OUT:
            begin
                v = t - ONE;
                return fx_mul(fx_mul(v, v), fx_mul(s + ONE, v) + s) + ONE;
            end
            FN_BACK_INOUT:
            begin
                s2 = fx_mul(s, (1525 * ONE + 500) / 1000);
                if (t < HALF) begin
                    w = 2 * t;
                    return round_shift(fx_mul(fx_mul(w, w), fx_mul(s2 + ONE, w) - s2), 1);
                end
                v = 2 * t - 2 * ONE;
                return round_shift(fx_mul(fx_mul(v, v), fx_mul(s2 + ONE, v) + s2) + 2 * ONE, 1);
            end
            FN_BNC_IN: return ONE - bounce_frac(ONE - t);
            FN_BNC_OUT: return bounce_frac(t);
            FN_BNC_INOUT:
            begin
                if (t < HALF) return round_shift(ONE - bounce_frac(ONE - 2 * t), 1);
                return round_shift(ONE + bounce_frac(2 * t - ONE), 1);
            end
            default: return 0;
        endcase
    endfunction

    function automatic logic signed [VAL_W-1:0] eased_value_of(
        input logic [FUNC_W-1:0] fn, input logic signed [PROG_W-1:0] prog,
        input logic signed [VAL_W-1:0] sv, input logic signed [VAL_W-1:0] ev);
        longint t, r;
        t = prog;
        if (t < 0) t = 0;
        if (t > ONE) t = ONE;
        r = longint'(sv) + round_shift((longint'(ev) - longint'(sv)) * ease_frac(fn, t), FB);
        if (r > 64'sd2147483647) r = 64'sd2147483647;
        if (r < -64'sd2147483648) r = -64'sd2147483648;
        return r[VAL_W-1:0];
    endfunction

    // send one word, record its expected result; valid stays up for the next word
    task automatic send_word(input logic [FUNC_W-1:0] fn, input logic signed [PROG_W-1:0] prog,
                             input logic signed [VAL_W-1:0] sv,
                             input logic signed [VAL_W-1:0] ev);
        while ($urandom_range(99) < send_idle_pct) begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid       <= 1'b1;
        item_ch.func        <= fn;
        item_ch.progress    <= prog;
        item_ch.start_value <= sv;
        item_ch.end_value   <= ev;
        do @(posedge clk); while (!item_ch.ready);
        eased_q.push_back(eased_value_of(fn, prog, sv, ev));
    endtask

    // drop the input valid, then wait for every result
    task automatic wait_drained();
        item_ch.valid <= 1'b0;
        while (eased_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_overshoot(input logic [OVS_W-1:0] val);
        wait_drained();
        cfg_ch.valid     <= 1'b1;
        cfg_ch.overshoot <= val;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid  <= 1'b0;
        overshoot_reg = val;
    endtask

    function automatic logic signed [PROG_W-1:0] rand_progress();
        case ($urandom_range(9))
            0: return PROG_W'($urandom);
            1: return PROG_W'(18'sd65536 + $urandom_range(3) - 1);
            2: return PROG_W'($urandom_range(2) - 1);
            default: return PROG_W'($urandom_range(65536));
        endcase
    endfunction

    function automatic logic signed [VAL_W-1:0] rand_value();
        case ($urandom_range(5))
            0: return $urandom;
            1: return $urandom_range(1) ? 32'sh7FFFFFFF : 32'sh80000000;
            default: return $signed($urandom_range(32'h00FF_FFFF)) - 32'sh0080_0000;
        endcase
    endfunction

    task automatic random_words(input int n, input int max_fn);
        for (int i = 0; i < n; i++)
            send_word(FUNC_W'($urandom_range(max_fn)), rand_progress(), rand_value(),
                      rand_value());
    endtask

    // every curve at its midpoint, plus endpoints, clamping, bad codes, saturation
    task automatic test_directed();
        logic [FUNC_W-1:0] fn;
        for (int f = 0; f <= 17; f++) begin
            fn = FUNC_W'(f);
            send_word(fn, 18'sd32768, 32'sh0000_0000, 32'sh0010_0000);
        end
        send_word(FN_QUAD_IN, -18'sd131072, 32'sh0001_0000, 32'sh0005_0000);
        send_word(FN_QUAD_OUT, 18'sd131071, 32'sh0001_0000, 32'sh0005_0000);
        send_word(FN_QUINT_INOUT, 18'sd0, 32'sh7FFF_FFFF, 32'sh8000_0000);
        send_word(FN_QUINT_INOUT, 18'sd65536, 32'sh7FFF_FFFF, 32'sh8000_0000);
        send_word(5'd18, 18'sd40000, 32'sh1234_5678, 32'sh0000_0000);
        send_word(5'd31, 18'sd40000, 32'sh8765_4321, 32'sh0000_0000);
        send_word(FN_BACK_OUT, 18'sd20000, 32'sh8000_0000, 32'sh7FFF_FFFF);
        send_word(FN_BACK_IN, 18'sd20000, 32'sh7FFF_FFFF, 32'sh8000_0000);
    endtask

    // random words under each idle mix
    task automatic test_idle_mixes();
        send_idle_pct = 0;  recv_stall_pct = 0;  random_words(300, 31);
        send_idle_pct = 53; recv_stall_pct = 0;  random_words(300, 17);
        send_idle_pct = 0;  recv_stall_pct = 53; random_words(300, 17);
        send_idle_pct = 15; recv_stall_pct = 15; random_words(300, 17);
    endtask

    // overshoot extremes and a mid value on the back curves
    task automatic test_overshoot();
        logic [OVS_W-1:0] vals[3];
        vals = '{15'd0, 15'd32767, 15'd12345};
        foreach (vals[i]) begin
            write_overshoot(vals[i]);
            send_word(FN_BACK_INOUT, 18'sd16384, 32'sh0000_0000, 32'sh0001_0000);
            random_words(80, 17);
        end
        write_overshoot(15'd6970);
    endtask

    // receiver holds off while the sender keeps offering
    task automatic test_backpressure();
        send_idle_pct = 0; recv_stall_pct = 0;
        hold_off = 1'b1;
        fork
            begin
                repeat (60) @(posedge clk);
                hold_off = 1'b0;
            end
            random_words(200, 17);
        join
    endtask

    // drive ready on the result side
    always @(posedge clk) begin
        if (hold_off)
            res_ch.ready <= 1'b0;
        else
            res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // compare each result word with the oldest expectation
    always @(posedge clk) begin
        if (rst_n && res_ch.valid && res_ch.ready) begin
            if (eased_q.size() == 0) begin
                $error("eased_value: unexpected word %0d", res_ch.eased_value);
                failed = 1'b1;
            end else begin
                if (res_ch.eased_value !== eased_q[0]) begin
                    $error("eased_value: expected %0d actual %0d",
                           eased_q[0], res_ch.eased_value);
                    failed = 1'b1;
                end
                void'(eased_q.pop_front());
            end
        end
    end

    // watchdog
    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > LIMIT_CYCLES) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        rst_n = 1'b0;
        failed = 1'b0;
        hold_off = 1'b0;
        cycle_cnt = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        overshoot_reg = 15'd6970;
        item_ch.valid = 1'b0;
        item_ch.func = '0;
        item_ch.progress = '0;
        item_ch.start_value = '0;
        item_ch.end_value = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.overshoot = '0;
        res_ch.ready = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_idle_mixes();
        test_backpressure();
        test_overshoot();
        recv_stall_pct = 0;
        wait_drained();
        if (!failed && eased_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire

// File: polynomial_back_bounce_easing_top.f
+incdir+rtl
rtl/pbbe_pkg.sv
rtl/pbbe_ifs.sv
rtl/polynomial_back_bounce_easing_top.sv
verif/polynomial_back_bounce_easing_top_test.sv
